// ----- rtl/ovl_pkg.sv -----
// Shared types and constants for the ordered value list.
// No dependencies; every other file imports this package.
package ovl_pkg;

    localparam int DEPTH          = 16;
    localparam int DATA_W         = 32;
    localparam int COUNT_W        = $clog2(DEPTH + 1);
    localparam int ENTRY_COUNT_W  = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_EXISTS = 2'd2,
        MODE_UPDATE = 2'd3
    } mode_t;

    typedef struct packed {
        logic                     ins_en;
        logic                     rem_en;
        logic                     upd_en;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] repl;
    } cell_cmd_t;

endpackage

// ----- rtl/ovl_cell.sv -----
// One list position: holds an entry, compares it with the key and shifts.
// Depends on ovl_pkg.
module ovl_cell
    import ovl_pkg::*;
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    input  logic                     occupied,
    input  logic signed [DATA_W-1:0] prev_entry,
    input  logic signed [DATA_W-1:0] next_entry,
    input  logic                     match_in,
    output logic                     match_out,
    output logic signed [DATA_W-1:0] entry
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     hit;

    assign hit       = occupied && (entry_reg == cmd.key);
    assign match_out = match_in | hit;
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins_en)
        begin
            entry_next = prev_entry;
        end
        else if (cmd.rem_en && match_out)
        begin
            entry_next = next_entry;
        end
        else if (cmd.upd_en && hit && !match_in)
        begin
            entry_next = cmd.repl;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/ordered_value_list_top.sv -----
// Top level of the ordered value list: a row of list cells plus count and result register.
// Depends on ovl_pkg and ovl_cell.
//
// The block keeps up to DEPTH signed 32-bit values, head first, in a row of
// cells that compare against the key in parallel and shift toward their
// neighbors. An input beat on in_valid/in_ready carries mode, key_value and
// replacement; each accepted beat yields exactly one result beat on
// out_valid/out_ready with success, full_refused and entry_count.
// The result appears in the cycle after the input beat is accepted, and the
// block takes one beat per cycle while out_ready keeps up: the cells and
// the count update in the accepting cycle; the result register holds the answer.
// When the receiver stalls, the result register holds its beat and
// in_ready stays low until that beat is taken, unless out_ready is high in
// the same cycle. Reset clears count_reg and the result valid flag, but
// not entry_count; the list is then empty and entries are written before they are read.
module ordered_value_list_top
    import ovl_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      mode,
    input  logic signed [DATA_W-1:0]        key_value,
    input  logic signed [DATA_W-1:0]        replacement,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            success,
    output logic                            full_refused,
    output logic [ENTRY_COUNT_W-1:0]        entry_count
);

    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     success_reg;
    logic                     success_next;
    logic                     refused_reg;
    logic                     refused_next;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg;
    logic [ENTRY_COUNT_W-1:0] entry_count_next;

    logic                     in_fire;
    logic                     full;
    logic                     any_match;
    mode_t                    op;
    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] entry_w [DEPTH];
    logic                     match_w [DEPTH+1];

    assign op       = mode_t'(mode);
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign full     = (count_reg == COUNT_W'(DEPTH));

    assign cmd.ins_en = in_fire && (op == MODE_INSERT) && !full;
    assign cmd.rem_en = in_fire && (op == MODE_REMOVE);
    assign cmd.upd_en = in_fire && (op == MODE_UPDATE);
    assign cmd.key    = key_value;
    assign cmd.repl   = replacement;

    assign match_w[0] = 1'b0;
    assign any_match  = match_w[DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] prev_entry;
        logic signed [DATA_W-1:0] next_entry;
        logic                     occupied;

        assign occupied = (COUNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign prev_entry = key_value;
        end
        else
        begin : g_body
            assign prev_entry = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_entry = entry_w[i];
        end
        else
        begin : g_inner
            assign next_entry = entry_w[i+1];
        end

        ovl_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .occupied   (occupied),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .match_in   (match_w[i]),
            .match_out  (match_w[i+1]),
            .entry      (entry_w[i])
        );
    end

    always_comb
    begin
        count_next   = count_reg;
        success_next = success_reg;
        refused_next = refused_reg;
        if (in_fire)
        begin
            refused_next = 1'b0;
            success_next = any_match;
            case (op)
                MODE_INSERT:
                begin
                    success_next = !full;
                    refused_next = full;
                    if (!full)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                MODE_REMOVE:
                begin
                    if (any_match)
                    begin
                        count_next = count_reg - COUNT_W'(1);
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        entry_count_next = in_fire ? ENTRY_COUNT_W'(count_next) : entry_count_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        success_reg     <= success_next;
        refused_reg     <= refused_next;
        entry_count_reg <= entry_count_next;
    end

    assign out_valid    = out_valid_reg;
    assign success      = success_reg;
    assign full_refused = refused_reg;
    assign entry_count  = entry_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("entry count exceeds list depth");

    a_refused_fails: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && refused_reg |-> !success_reg)
        else $error("refused insert reported as success");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (op == MODE_INSERT) && !full |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("accepted insert did not grow the list");

    a_miss_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (op != MODE_INSERT) && !any_match |=> $stable(count_reg))
        else $error("count changed on an operation without a match");

endmodule
